/* src/isingm_pkg.sv */
// ============================================================================
// isingm_pkg: shared types and constants for the Ising spin update block
// Lattice geometry, field widths, register indexes and the structs that pass
// between the front end, the request queue and the update engine.
// ============================================================================
`default_nettype none

package isingm_pkg;

    // Lattice geometry: SIDE by SIDE spins, one memory row per lattice row.
    localparam int SIDE_BITS = 7;
    localparam int SIDE      = 1 << SIDE_BITS;
    localparam int RAND_BITS = 16;

    // Field widths fixed by the interface.
    localparam int ROW_FIELD_W  = 7;
    localparam int COL_FIELD_W  = 7;
    localparam int RAND_FIELD_W = 16;
    localparam int THRESH_W     = 16;
    localparam int DE_W         = 5;
    localparam int MAG_W        = 16;
    localparam int ENERGY_W     = 17;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int CFG_IDX_W    = 1;

    // Request queue between front end and update engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values: all spins up.
    localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SIDE * SIDE);
    localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
    localparam logic [THRESH_W-1:0]        THRESH_FOUR_RESET  = THRESH_W'(4555);
    localparam logic [THRESH_W-1:0]        THRESH_EIGHT_RESET = THRESH_W'(317);

    // Energy change that selects the threshold in register 0, THRESH_FOUR.
    localparam logic signed [DE_W-1:0] DE_FOUR = DE_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH_FOUR  = 1'b0,
        REG_THRESH_EIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [SIDE_BITS-1:0] t_coord;

    // One classified site request: the site and its wrapped neighbours.
    typedef struct packed {
        t_coord               row;
        t_coord               row_nx;
        t_coord               row_pv;
        t_coord               col;
        t_coord               col_nx;
        t_coord               col_pv;
        logic [RAND_BITS-1:0] rnd;
    } t_req;

    typedef struct packed {
        logic [THRESH_W-1:0] four;
        logic [THRESH_W-1:0] eight;
    } t_thresh;

    // Result beat, packed so that the last field lands in the lowest bits.
    typedef struct packed {
        logic signed [ENERGY_W-1:0] total_energy;
        logic signed [MAG_W-1:0]    magnetization_sum;
        logic signed [DE_W-1:0]     energy_change;
        logic                       new_spin;
        logic                       flipped;
    } t_result;

endpackage

`default_nettype wire

/* src/isingm_front.sv */
// ============================================================================
// isingm_front: input stage
// Takes site beats, wraps the neighbour coordinates and hands the request on.
// ============================================================================
`default_nettype none

module isingm_front
    import isingm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_enable,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       o_req_valid,
    output t_req                       o_req,
    input  wire logic                  i_req_ready
);

    logic r_valid;
    t_req r_req;
    t_req n_req;
    logic accept;

    assign s_axis_tready = i_enable && (!r_valid || i_req_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Each index field is SIDE_BITS wide, so all of its bits address the lattice.
    always_comb begin
        n_req.row    = s_axis_tdata[SIDE_BITS-1:0];
        n_req.col    = s_axis_tdata[ROW_FIELD_W +: SIDE_BITS];
        n_req.rnd    = s_axis_tdata[ROW_FIELD_W + COL_FIELD_W +: RAND_BITS];
        n_req.row_nx = n_req.row + t_coord'(1);
        n_req.row_pv = n_req.row - t_coord'(1);
        n_req.col_nx = n_req.col + t_coord'(1);
        n_req.col_pv = n_req.col - t_coord'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_req_ready) begin
            r_valid <= accept;
        end
        if (accept) begin
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

`default_nettype wire

/* src/isingm_queue.sv */
// ============================================================================
// isingm_queue: request queue
// A short first-in first-out buffer between the front end and the engine.
// ============================================================================
`default_nettype none

module isingm_queue
    import isingm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_req i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop,
    output t_req      o_pop_data
);

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_data   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* src/isingm_back.sv */
// ============================================================================
// isingm_back: update engine
// Holds the spin lattice, reads the three rows around a site, decides the
// flip, writes the row back and keeps magnetization and energy up to date.
// ============================================================================
`default_nettype none

module isingm_back
    import isingm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_thresh i_thresh,
    input  wire logic    i_req_valid,
    input  wire t_req    i_req,
    output logic         o_req_pop,
    output logic         o_clear_done,
    output logic         o_res_valid,
    output t_result      o_res,
    input  wire logic    i_res_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_NX,
        S_RD_PV,
        S_RD_MID,
        S_EXEC
    } t_state;

    logic [SIDE-1:0] mem [SIDE];
    logic [SIDE-1:0] r_rd_data;

    t_state                     r_state;
    t_coord                     r_clr_row;
    t_req                       r_req;
    logic                       r_nb_nx;
    logic                       r_nb_pv;
    logic                       r_nb_lt;
    logic                       r_nb_rt;
    logic                       r_spin;
    logic [SIDE-1:0]            r_row_word;
    logic signed [MAG_W-1:0]    r_mag;
    logic signed [ENERGY_W-1:0] r_energy;
    logic                       r_out_valid;
    t_result                    r_out;

    t_coord                     rd_addr;
    t_coord                     wr_addr;
    logic [SIDE-1:0]            wr_data;
    logic                       wr_en;
    logic                       pop;
    logic [2:0]                 up_count;
    logic signed [DE_W-1:0]     de_up;
    logic signed [DE_W-1:0]     de;
    logic                       flip;
    logic signed [MAG_W-1:0]    n_mag;
    logic signed [ENERGY_W-1:0] n_energy;

    assign pop = (r_state == S_IDLE) && i_req_valid && (!r_out_valid || i_res_ready);

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = i_req.row_nx;
            S_RD_NX: rd_addr = r_req.row_pv;
            default: rd_addr = r_req.row;
        endcase
    end

    // Energy change 2*s*sum(neighbours), the sum being 2*ups - 4.
    always_comb begin
        up_count = 3'({2'b00, r_nb_nx}) + 3'({2'b00, r_nb_pv})
                 + 3'({2'b00, r_nb_lt}) + 3'({2'b00, r_nb_rt});
        de_up    = DE_W'({up_count, 2'b00}) - DE_W'(8);
        de       = r_spin ? de_up : -de_up;
        priority if (de[DE_W-1] || (de == '0)) begin
            flip = 1'b1;
        end else if (de == DE_FOUR) begin
            flip = r_req.rnd < i_thresh.four[RAND_BITS-1:0];
        end else begin
            flip = r_req.rnd < i_thresh.eight[RAND_BITS-1:0];
        end
        n_mag    = r_mag;
        n_energy = r_energy;
        if (flip) begin
            n_mag    = r_spin ? r_mag - MAG_W'(2) : r_mag + MAG_W'(2);
            n_energy = r_energy + ENERGY_W'(de);
        end
    end

    assign wr_en   = (r_state == S_CLEAR) || (r_state == S_EXEC);
    assign wr_addr = (r_state == S_CLEAR) ? r_clr_row : r_req.row;
    assign wr_data = (r_state == S_CLEAR) ? '1
                   : (r_row_word ^ (SIDE'(flip) << r_req.col));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_mag       <= MAG_RESET;
            r_energy    <= ENERGY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + t_coord'(1);
                    if (r_clr_row == t_coord'(SIDE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_req   <= i_req;
                        r_state <= S_RD_NX;
                    end
                end
                S_RD_NX: begin
                    r_nb_nx <= r_rd_data[r_req.col];
                    r_state <= S_RD_PV;
                end
                S_RD_PV: begin
                    r_nb_pv <= r_rd_data[r_req.col];
                    r_state <= S_RD_MID;
                end
                S_RD_MID: begin
                    r_spin     <= r_rd_data[r_req.col];
                    r_nb_lt    <= r_rd_data[r_req.col_pv];
                    r_nb_rt    <= r_rd_data[r_req.col_nx];
                    r_row_word <= r_rd_data;
                    r_state    <= S_EXEC;
                end
                S_EXEC: begin
                    r_mag                   <= n_mag;
                    r_energy                <= n_energy;
                    r_out.flipped           <= flip;
                    r_out.new_spin          <= r_spin ^ flip;
                    r_out.energy_change     <= de;
                    r_out.magnetization_sum <= n_mag;
                    r_out.total_energy      <= n_energy;
                    r_out_valid             <= 1'b1;
                    r_state                 <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_pop    = pop;
    assign o_clear_done = (r_state != S_CLEAR);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

    // The result register is always free by the time a site is resolved.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result register still occupied when a site resolves");

    // Every flip moves the magnetization by two, so it stays even.
    a_mag_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag[0] == 1'b0)
        else $error("magnetization became odd");

    // Energy steps are multiples of four.
    a_energy_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_energy[1:0] == 2'b00)
        else $error("total energy left the multiples of four");

    // No request is taken from the queue before the lattice is initialised.
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !pop)
        else $error("request popped during the lattice clearing pass");

endmodule

`default_nettype wire

/* src/ising_metropolis_spin_update.sv */
// ============================================================================
// ising_metropolis_spin_update: 2-D Ising lattice, Metropolis spin update
// Top level: configuration registers, input stage, request queue and the
// update engine that owns the lattice memory.
// ============================================================================
// The block holds a 128 by 128 lattice of spins with wrap-around edges, all up
// after reset. Each input beat names a site and carries a 16-bit random
// fraction; each one yields exactly one result beat giving whether the spin
// flipped, its new value, the energy change 2*s*(sum of the four neighbours),
// and the running magnetization and total energy after the step. A change of
// zero or less always flips; a change of 4 or 8 flips only when the random
// fraction is strictly below the threshold held in register 0 or 1. After
// reset the lattice memory is set to all ones one row per cycle, and
// s_axis_tready stays low until that pass has finished; configuration
// writes are taken throughout. Sites are then processed one at a time:
// the lattice memory is read for the row below, the row above and the
// site's own row, and that row is written back in the final state,
// S_EXEC, when the result is loaded into the output register. An input
// stage and a two-entry queue sit in front of the engine, so new beats
// are taken while a site is being worked on or while a result waits for
// m_axis_tready. Thresholds should only be written while no beat is in
// flight.
// ============================================================================
`default_nettype none

module ising_metropolis_spin_update
    import isingm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [THRESH_W-1:0]    i_cfg_wdata,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [6:0] site_row, [13:7] site_col, [29:14] random_fraction, [31:30] ignored
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] flipped, [1] new_spin, [6:2] energy_change,
    // [22:7] magnetization_sum, [39:23] total_energy
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    t_thresh r_thresh;

    logic    front_valid;
    t_req    front_req;
    logic    queue_ready;
    logic    queue_valid;
    t_req    queue_req;
    logic    req_pop;
    logic    clear_done;
    t_result result;

    // Threshold registers; the index selects which one a write lands in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.four  <= THRESH_FOUR_RESET;
            r_thresh.eight <= THRESH_EIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_THRESH_FOUR:  r_thresh.four  <= i_cfg_wdata;
                REG_THRESH_EIGHT: r_thresh.eight <= i_cfg_wdata;
                default:          r_thresh       <= r_thresh;
            endcase
        end
    end

    // Input stage: takes a beat and works out the wrapped neighbour sites.
    isingm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (clear_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_req_valid   (front_valid),
        .o_req         (front_req),
        .i_req_ready   (queue_ready)
    );

    // Queue that lets the input side run ahead of the update engine.
    isingm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (queue_ready),
        .i_push_data  (front_req),
        .o_pop_valid  (queue_valid),
        .i_pop        (req_pop),
        .o_pop_data   (queue_req)
    );

    // Update engine with the lattice memory and the running sums.
    isingm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_thresh     (r_thresh),
        .i_req_valid  (queue_valid),
        .i_req        (queue_req),
        .o_req_pop    (req_pop),
        .o_clear_done (clear_done),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (result),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = result;

endmodule

`default_nettype wire
